// ===== src/mswpt_pkg.sv =====
// ============================================================================
// mswpt_pkg
// Shared types and constants for the wheel period and temperature extractor.
// ============================================================================
package mswpt_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TICK_W   = 10;
    localparam int COUNT_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 16'd1000;
    localparam logic [TICK_W-1:0]   RST_TICK      = 10'd100;
    localparam logic [COUNT_W-1:0]  RST_TIMEOUT   = 24'd1000000;
    localparam logic [COUNT_W-1:0]  RST_WINDOW    = 24'd500000;
    localparam logic [SAMPLE_W-1:0] RST_INIT_TEMP = 16'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_US             = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_WINDOW_US      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TEMPERATURE = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [TICK_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {{(COUNT_W-TICK_W+1){1'b0}}, b};
        return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

endpackage

// ===== src/mswpt_ram.sv =====
// ============================================================================
// mswpt_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module mswpt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/mixed_signal_wheel_period_and_temp.sv =====
// ============================================================================
// mixed_signal_wheel_period_and_temp
// Pulse width averaging and peak-hold temperature from one mixed ADC signal.
// ============================================================================
// A sample that ends no pulse goes from IDLE straight to FIN. A sample that ends a pulse
// first sums the ring through the RAM read port (SUM), then runs a restoring divider that
// retires one quotient bit per cycle (DIV), then finishes (FIN). FIN registers the result
// once the output register is free. A new sample is taken only in IDLE, after the last one
// is finished; the next sample is taken while a result waits. Reset (rst_n low,
// asynchronous) clears counters, ring fill and out_valid.
module mixed_signal_wheel_period_and_temp #(
    parameter int AVG_DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mswpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mswpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mswpt_pkg::SAMPLE_W-1:0]     sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mswpt_pkg::COUNT_W-1:0]      wheel_period_us,
    output logic [mswpt_pkg::SAMPLE_W-1:0]     temperature_raw,
    output logic                               new_period,
    output logic                               timed_out
);

    localparam int IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W  = mswpt_pkg::COUNT_W + FILL_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam int CW = mswpt_pkg::COUNT_W;
    localparam int SW = mswpt_pkg::SAMPLE_W;
    localparam int TW = mswpt_pkg::TICK_W;

    // configuration
    logic [SW-1:0] thr_reg, thr_next;
    logic [TW-1:0] tick_reg, tick_next;
    logic [CW-1:0] tmo_reg, tmo_next;
    logic [CW-1:0] win_reg, win_next;

    // measurement state
    mswpt_pkg::state_t state_reg, state_next;
    logic              low_seen_reg, low_seen_next;
    logic              rise_seen_reg, rise_seen_next;
    logic [CW-1:0]     pc_reg, pc_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CW-1:0]     avg_reg, avg_next;
    logic [SW-1:0]     peak_reg, peak_next;
    logic [CW-1:0]     wcnt_reg, wcnt_next;
    logic [SW-1:0]     pub_reg, pub_next;

    // per transaction working registers
    logic [SW-1:0]     samp_reg, samp_next;
    logic              done_reg, done_next;
    logic [FILL_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    // output register
    logic              ovld_reg, ovld_next;
    logic [CW-1:0]     o_period_reg, o_period_next;
    logic [SW-1:0]     o_temp_reg, o_temp_next;
    logic              o_new_reg, o_new_next;
    logic              o_tout_reg, o_tout_next;

    // ring
    logic              wr_en;
    logic [CW-1:0]     wr_data;
    logic              rd_en;
    logic [CW-1:0]     rd_data;

    // accept path
    logic              accept;
    logic              low;
    logic              rise_now;
    logic              done_now;
    logic [CW-1:0]     pc_inc;

    // divider step
    logic [FILL_W:0]   rem_sh;
    logic              div_ge;

    // finish step
    logic              tout;
    logic [CW-1:0]     avg_fin;
    logic [SW-1:0]     peak_fin;
    logic              publish;
    logic              out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == mswpt_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !ovld_reg || out_ready;

    assign low      = sample < thr_reg;
    assign rise_now = !low && low_seen_reg && !rise_seen_reg;
    assign done_now = low && rise_seen_reg;
    assign pc_inc   = mswpt_pkg::sat_add(rise_now ? '0 : pc_reg, tick_reg);

    assign wr_en   = accept && done_now;
    assign wr_data = pc_inc;
    assign rd_en   = (state_reg == mswpt_pkg::ST_SUM) && (rd_cnt_reg != fill_reg);

    assign rem_sh = {rem_reg, acc_reg[SUM_W-1]};
    assign div_ge = rem_sh >= {1'b0, fill_reg};

    assign tout     = pc_reg >= tmo_reg;
    assign avg_fin  = tout ? '0 : avg_reg;
    assign peak_fin = (samp_reg > peak_reg) ? samp_reg : peak_reg;
    assign publish  = (peak_fin > thr_reg) && (wcnt_reg >= win_reg) && (avg_fin != '0);

    mswpt_ram #(
        .WIDTH  (CW),
        .DEPTH  (AVG_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        thr_next  = thr_reg;
        tick_next = tick_reg;
        tmo_next  = tmo_reg;
        win_next  = win_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mswpt_pkg::REG_SIGNAL_THRESHOLD: thr_next  = cfg_data[SW-1:0];
                mswpt_pkg::REG_TICK_US:          tick_next = cfg_data[TW-1:0];
                mswpt_pkg::REG_TIMEOUT_US:       tmo_next  = cfg_data[CW-1:0];
                mswpt_pkg::REG_TEMP_WINDOW_US:   win_next  = cfg_data[CW-1:0];
                // initial temperature writes are ignored; reset loads RST_INIT_TEMP instead
                mswpt_pkg::REG_INITIAL_TEMPERATURE: ;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        low_seen_next  = low_seen_reg;
        rise_seen_next = rise_seen_reg;
        pc_next        = pc_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        avg_next       = avg_reg;
        peak_next      = peak_reg;
        wcnt_next      = wcnt_reg;
        pub_next       = pub_reg;
        samp_next      = samp_reg;
        done_next      = done_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_vld_next    = 1'b0;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        ovld_next      = ovld_reg;
        o_period_next  = o_period_reg;
        o_temp_next    = o_temp_reg;
        o_new_next     = o_new_reg;
        o_tout_next    = o_tout_reg;

        if (ovld_reg && out_ready)
        begin
            ovld_next = 1'b0;
        end

        case (state_reg)
            mswpt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    samp_next   = sample;
                    done_next   = done_now;
                    acc_next    = '0;
                    rem_next    = '0;
                    dcnt_next   = '0;
                    rd_cnt_next = '0;
                    if (done_now)
                    begin
                        low_seen_next  = 1'b0;
                        rise_seen_next = 1'b0;
                        pc_next        = '0;
                        if (fill_reg != FILL_W'(AVG_DEPTH))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        idx_next   = (idx_reg == IDX_W'(AVG_DEPTH - 1)) ? '0
                                                                        : idx_reg + 1'b1;
                        state_next = mswpt_pkg::ST_SUM;
                    end
                    else
                    begin
                        low_seen_next = low_seen_reg || low;
                        if (rise_now)
                        begin
                            rise_seen_next = 1'b1;
                        end
                        pc_next    = pc_inc;
                        state_next = mswpt_pkg::ST_FIN;
                    end
                end
            end
            mswpt_pkg::ST_SUM:
            begin
                if (rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    acc_next = acc_reg + SUM_W'(rd_data);
                end
                if (!rd_en && !rd_vld_reg)
                begin
                    state_next = mswpt_pkg::ST_DIV;
                end
            end
            mswpt_pkg::ST_DIV:
            begin
                if (dcnt_reg == DCNT_W'(SUM_W))
                begin
                    avg_next   = acc_reg[CW-1:0];
                    state_next = mswpt_pkg::ST_FIN;
                end
                else
                begin
                    rem_next  = div_ge ? FILL_W'(rem_sh - {1'b0, fill_reg})
                                       : rem_sh[FILL_W-1:0];
                    acc_next  = {acc_reg[SUM_W-2:0], div_ge};
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            mswpt_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    if (tout)
                    begin
                        avg_next       = '0;
                        pc_next        = '0;
                        idx_next       = '0;
                        fill_next      = '0;
                        low_seen_next  = 1'b0;
                        rise_seen_next = 1'b0;
                    end
                    if (publish)
                    begin
                        pub_next  = peak_fin;
                        peak_next = '0;
                        wcnt_next = mswpt_pkg::sat_add('0, tick_reg);
                    end
                    else
                    begin
                        peak_next = peak_fin;
                        wcnt_next = mswpt_pkg::sat_add(wcnt_reg, tick_reg);
                    end
                    ovld_next     = 1'b1;
                    o_period_next = avg_fin;
                    o_temp_next   = publish ? peak_fin : pub_reg;
                    o_new_next    = done_reg;
                    o_tout_next   = tout;
                    state_next    = mswpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mswpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= mswpt_pkg::RST_THRESHOLD;
            tick_reg      <= mswpt_pkg::RST_TICK;
            tmo_reg       <= mswpt_pkg::RST_TIMEOUT;
            win_reg       <= mswpt_pkg::RST_WINDOW;
            state_reg     <= mswpt_pkg::ST_IDLE;
            low_seen_reg  <= 1'b0;
            rise_seen_reg <= 1'b0;
            pc_reg        <= '0;
            idx_reg       <= '0;
            fill_reg      <= '0;
            avg_reg       <= '0;
            peak_reg      <= mswpt_pkg::RST_INIT_TEMP;
            wcnt_reg      <= '0;
            pub_reg       <= mswpt_pkg::RST_INIT_TEMP;
            rd_vld_reg    <= 1'b0;
            ovld_reg      <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            tick_reg      <= tick_next;
            tmo_reg       <= tmo_next;
            win_reg       <= win_next;
            state_reg     <= state_next;
            low_seen_reg  <= low_seen_next;
            rise_seen_reg <= rise_seen_next;
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            avg_reg       <= avg_next;
            peak_reg      <= peak_next;
            wcnt_reg      <= wcnt_next;
            pub_reg       <= pub_next;
            rd_vld_reg    <= rd_vld_next;
            ovld_reg      <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg     <= samp_next;
        done_reg     <= done_next;
        rd_cnt_reg   <= rd_cnt_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        o_period_reg <= o_period_next;
        o_temp_reg   <= o_temp_next;
        o_new_reg    <= o_new_next;
        o_tout_reg   <= o_tout_next;
    end

    assign out_valid       = ovld_reg;
    assign wheel_period_us = o_period_reg;
    assign temperature_raw = o_temp_reg;
    assign new_period      = o_new_reg;
    assign timed_out       = o_tout_reg;

endmodule

// ===== src/mswpt_checker.sv =====
// ============================================================================
// mswpt_checker
// Port-level checks for the wheel period and temperature extractor.
// ============================================================================
module mswpt_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [mswpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mswpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [mswpt_pkg::SAMPLE_W-1:0]     sample,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [mswpt_pkg::COUNT_W-1:0]      wheel_period_us,
    input  logic [mswpt_pkg::SAMPLE_W-1:0]     temperature_raw,
    input  logic                               new_period,
    input  logic                               timed_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wheel_period_us)
            && $stable(temperature_raw) && $stable(new_period) && $stable(timed_out))
        else $error("result changed while stalled");

    // a timeout always reports a zero period
    a_tout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> wheel_period_us == '0)
        else $error("timeout with nonzero period");

    // one transaction in flight: busy right after an input transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a result is raised only as the block turns ready for the next sample
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while busy");

endmodule

bind mixed_signal_wheel_period_and_temp mswpt_checker u_mswpt_checker (.*);

// ===== test/mixed_signal_wheel_period_and_temp_tb.sv =====
// ============================================================================
// mixed_signal_wheel_period_and_temp_tb
// Self-checking bench for the wheel period and temperature extractor. A
// tracker class keeps its own copy of the pulse qualifier, the width ring,
// the mean and the temperature peak hold. It predicts one reading for every
// accepted sample and checks each reading that is delivered. Stimulus runs
// through register settings that include the zero and full-scale values,
// with bursty input and a stalling output side.
// ============================================================================
module mixed_signal_wheel_period_and_temp_tb;

    localparam int CW = mswpt_pkg::COUNT_W;
    localparam int SW = mswpt_pkg::SAMPLE_W;
    localparam int TW = mswpt_pkg::TICK_W;
    localparam int IW = mswpt_pkg::CFG_IDX_W;
    localparam int DW = mswpt_pkg::CFG_DATA_W;

    localparam int RING_DEPTH  = 8;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct packed {
        logic [CW-1:0] period;
        logic [SW-1:0] temp;
        logic          new_p;
        logic          tmo;
    } reading_t;

    class pulse_temp_tracker;
        logic [SW-1:0] thr       = mswpt_pkg::RST_THRESHOLD;
        logic [TW-1:0] tick      = mswpt_pkg::RST_TICK;
        logic [CW-1:0] tout      = mswpt_pkg::RST_TIMEOUT;
        logic [CW-1:0] win       = mswpt_pkg::RST_WINDOW;
        logic [SW-1:0] init_temp = mswpt_pkg::RST_INIT_TEMP;

        logic          low_seen   = 1'b0;
        logic          rise_seen  = 1'b0;
        logic [CW-1:0] period_cnt = '0;
        logic [CW-1:0] ring [RING_DEPTH];
        int            ring_idx   = 0;
        int            ring_fill  = 0;
        logic [CW-1:0] avg        = '0;
        logic [SW-1:0] peak       = mswpt_pkg::RST_INIT_TEMP;
        logic [CW-1:0] win_cnt    = '0;
        logic [SW-1:0] pub        = mswpt_pkg::RST_INIT_TEMP;

        reading_t      expected_readings [$];
        int            errors = 0;

        function automatic logic [CW-1:0] add_sat(logic [CW-1:0] a, logic [TW-1:0] b);
            logic [CW:0] s;
            s = {1'b0, a} + b;
            return s[CW] ? mswpt_pkg::COUNT_MAX : s[CW-1:0];
        endfunction

        // initial_temperature is stored but unused; reset happens once, before any write
        function void write_reg(logic [IW-1:0] idx, logic [DW-1:0] d);
            case (idx)
                mswpt_pkg::REG_SIGNAL_THRESHOLD:    thr       = d[SW-1:0];
                mswpt_pkg::REG_TICK_US:             tick      = d[TW-1:0];
                mswpt_pkg::REG_TIMEOUT_US:          tout      = d[CW-1:0];
                mswpt_pkg::REG_TEMP_WINDOW_US:      win       = d[CW-1:0];
                mswpt_pkg::REG_INITIAL_TEMPERATURE: init_temp = d[SW-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SW-1:0] s);
            reading_t        r;
            logic            low;
            logic            done;
            logic            tmo;
            longint unsigned sum;
            low  = s < thr;
            done = 1'b0;
            tmo  = 1'b0;
            if (low)
                low_seen = 1'b1;
            if (!low && low_seen && !rise_seen)
            begin
                rise_seen  = 1'b1;
                period_cnt = '0;
            end
            period_cnt = add_sat(period_cnt, tick);
            // fall is seen and the pulse ends on the same low sample
            if (low && rise_seen)
                done = 1'b1;
            if (done)
            begin
                low_seen       = 1'b0;
                rise_seen      = 1'b0;
                ring[ring_idx] = period_cnt;
                period_cnt     = '0;
                if (ring_fill < RING_DEPTH)
                    ring_fill++;
                sum = 0;
                for (int n = 0; n < ring_fill; n++)
                    sum += ring[n];
                avg      = CW'(sum / ring_fill);
                ring_idx = (ring_idx + 1) % RING_DEPTH;
            end
            if (period_cnt >= tout)
            begin
                tmo        = 1'b1;
                avg        = '0;
                period_cnt = '0;
                ring_idx   = 0;
                ring_fill  = 0;
                low_seen   = 1'b0;
                rise_seen  = 1'b0;
            end
            if (s > peak)
                peak = s;
            if (peak > thr && win_cnt >= win && avg != '0)
            begin
                pub     = peak;
                peak    = '0;
                win_cnt = '0;
            end
            win_cnt = add_sat(win_cnt, tick);
            r.period = avg;
            r.temp   = pub;
            r.new_p  = done;
            r.tmo    = tmo;
            expected_readings.push_back(r);
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("MISMATCH %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_reading(logic [CW-1:0] period, logic [SW-1:0] temp,
                           logic new_p, logic tmo);
            reading_t e;
            if (expected_readings.size() == 0)
            begin
                report("unexpected transaction", 1, 0);
            end
            else
            begin
                e = expected_readings.pop_front();
                if (period !== e.period) report("wheel_period_us", period, e.period);
                if (temp !== e.temp)     report("temperature_raw", temp, e.temp);
                if (new_p !== e.new_p)   report("new_period", new_p, e.new_p);
                if (tmo !== e.tmo)       report("timed_out", tmo, e.tmo);
            end
        endtask

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [IW-1:0] cfg_index = '0;
    logic [DW-1:0] cfg_data  = '0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    logic [SW-1:0] sample    = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [CW-1:0] wheel_period_us;
    logic [SW-1:0] temperature_raw;
    logic          new_period;
    logic          timed_out;

    pulse_temp_tracker tracker = new();

    int burst_left = 0;
    int cycles     = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    int run_left   = 0;
    logic stall_rdy = 1'b1;

    mixed_signal_wheel_period_and_temp #(.AVG_DEPTH(RING_DEPTH)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .wheel_period_us (wheel_period_us),
        .temperature_raw (temperature_raw),
        .new_period      (new_period),
        .timed_out       (timed_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern: always ready, coin flip, one in three, long runs
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            0: stall_rdy = 1'b1;
            1: stall_rdy = 1'($urandom_range(0, 1));
            2: stall_rdy = (mode_left % 3 == 0);
            default:
            begin
                if (run_left == 0)
                begin
                    stall_rdy = !stall_rdy;
                    run_left  = stall_rdy ? $urandom_range(1, 8) : $urandom_range(1, 12);
                end
                run_left--;
            end
        endcase
        out_ready <= stall_rdy;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_reading(wheel_period_us, temperature_raw, new_period, timed_out);
    end

    function automatic logic [SW-1:0] low_value();
        int unsigned t;
        t = tracker.thr;
        if (t == 0)
            return SW'($urandom);
        return SW'($urandom_range(t - 1, 0));
    endfunction

    function automatic logic [SW-1:0] high_value();
        int unsigned t;
        t = tracker.thr;
        return SW'($urandom_range(65535, t));
    endfunction

    task automatic send_sample(input logic [SW-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_sample(s);
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [IW-1:0] idx, input logic [DW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.write_reg(idx, d);
    endtask

    // unused upper data bits carry noise; one write goes to an unmapped index
    task automatic program_regs(input logic [SW-1:0] thr, input logic [TW-1:0] tick,
                                input logic [CW-1:0] tout, input logic [CW-1:0] win,
                                input logic [SW-1:0] init);
        cfg_put(mswpt_pkg::REG_SIGNAL_THRESHOLD, {8'($urandom), thr});
        cfg_put(mswpt_pkg::REG_TICK_US, {14'($urandom), tick});
        cfg_put(mswpt_pkg::REG_TIMEOUT_US, tout);
        cfg_put(mswpt_pkg::REG_TEMP_WINDOW_US, win);
        cfg_put(mswpt_pkg::REG_INITIAL_TEMPERATURE, {8'($urandom), init});
        cfg_put(IW'($urandom_range(5, 7)), DW'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed pulses, with noise, rail values and broken pulses
    task automatic run_mix(input int n, input int max_run);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                len = $urandom_range(1, 3);
                repeat (len) send_sample(low_value());
                sent += len;
                len = $urandom_range(1, max_run);
                repeat (len) send_sample(high_value());
                sent += len;
                send_sample(low_value());
                sent++;
            end
            else if (kind == 7)
            begin
                send_sample(SW'($urandom));
                sent++;
            end
            else if (kind == 8)
            begin
                send_sample($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                sent++;
            end
            else
            begin
                len = $urandom_range(1, max_run);
                repeat (len) send_sample(high_value());
                sent += len;
            end
        end
        drain();
    endtask

    task automatic run_random_setting(input int n);
        logic [TW-1:0] tick;
        tick = TW'($urandom_range(1, 1023));
        program_regs(SW'($urandom), tick, CW'(tick * $urandom_range(5, 60)),
                     CW'(tick * $urandom_range(1, 200)), SW'($urandom));
        run_mix(n, 50);
    endtask

    initial
    begin
        logic [SW-1:0] directed [];
        directed = '{16'd1000, 16'd999, 16'd1000, 16'd0,
                     16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0,
                     16'hFFFF, 16'd999, 16'hAAAA, 16'h5555,
                     16'd500, 16'd1001, 16'd998, 16'd2000,
                     16'd3};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        foreach (directed[i])
            send_sample(directed[i]);
        drain();

        program_regs(16'd1000, 10'd100, 24'd3000, 24'd2000, 16'hFFFF);
        run_mix(400, 40);

        // zero timeout fires on every sample, so no pulse ever completes
        program_regs(16'd30000, 10'd7, 24'd0, 24'd0, 16'h0000);
        run_mix(100, 6);

        // no sample is ever low, timeout zero, full tick
        program_regs(16'd0, 10'd1023, 24'd0, 24'd0, 16'h1234);
        run_mix(60, 6);

        // zero tick: counters stand still, full threshold
        program_regs(16'hFFFF, 10'd0, 24'd1, 24'hFFFFFF, 16'hFFFF);
        run_mix(100, 6);

        program_regs(16'd40000, 10'd1, 24'd100, 24'd50, 16'h8000);
        run_mix(300, 120);

        repeat (3) run_random_setting(300);

        program_regs(16'd1000, 10'd100, 24'd1000000, 24'd500000, 16'd0);
        run_mix(100, 30);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
